>>> hdl/assert_macros.svh
// Assertion macros shared by the offset-fill RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> hdl/bsof_pkg.sv
// Package for the bucket sieve offset-fill block: payload types, codes,
// sequencer states and default parameter values. No dependencies.
`timescale 1ns / 1ps

package bsof_pkg;

  // Default parameter values
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int FLAG_BITS_DEF    = 18;
  localparam int SLOT_LIMIT_DEF   = 4096;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_CLASS_OFFSET    = 2'd0;
  localparam logic [1:0] REG_BLOCKS_IN_USE   = 2'd1;
  localparam logic [1:0] REG_LARGE_THRESHOLD = 2'd2;

  // Input commands
  typedef enum logic {
    CMD_LINE  = 1'b0,
    CMD_PRIME = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] prime;
    logic [31:0] inverse;
    logic [31:0] low_residue;
  } in_item_t;

  typedef struct packed {
    logic [31:0] start_offset;
    logic        hit;
    logic [5:0]  bucket;
    logic [11:0] slot;
    logic [63:0] entry;
    logic        large_mode;
    logic        overflow;
  } out_item_t;

  // Top-level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_LOOK,
    S_FIN
  } seq_state_t;

  // Multiply / remainder unit
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  // Counter bank control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
    logic clear_large;
    logic upper_bank;
  } cnt_ctrl_t;

endpackage

>>> hdl/bsof_muldiv.sv
// Shared radix-4 unit: 32x32 multiply, then remainder of the 64-bit product
// by a 32-bit divisor, two bits per cycle. Depends on bsof_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsof_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         op_a,
  input  logic [31:0]         op_b,
  input  logic [31:0]         op_d,
  output bsof_pkg::md_stat_t  stat,
  output logic [31:0]         rem
);

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  bsof_pkg::md_state_t state;
  logic [4:0]  step;
  logic [63:0] w;
  logic [31:0] opa;
  logic [31:0] dvs;
  logic [33:0] tri3;
  logic [31:0] rem_r;
  logic        done_r;

  logic [31:0] tri_src;
  logic [33:0] tri_sum;
  logic [33:0] pp;
  logic [33:0] msum;
  logic [63:0] w_mul;
  logic [33:0] t;
  logic [33:0] dsel;
  logic [33:0] diff;

  // Triple of the current operand: multiplicand at start, divisor later
  assign tri_src = (state == bsof_pkg::MD_IDLE) ? op_a : dvs;
  assign tri_sum = {2'b00, tri_src} + {1'b0, tri_src, 1'b0};

  // Multiply step: add digit times multiplicand to the high half, shift right
  always_comb begin
    case (w[1:0])
      2'd0:    pp = 34'd0;
      2'd1:    pp = {2'b00, opa};
      2'd2:    pp = {1'b0, opa, 1'b0};
      default: pp = tri3;
    endcase
  end
  assign msum  = {2'b00, w[63:32]} + pp;
  assign w_mul = {msum, w[31:2]};

  // Remainder step: bring in two dividend bits, subtract the largest multiple
  assign t = {rem_r, w[63:62]};
  always_comb begin
    if (t >= tri3) begin
      dsel = tri3;
    end else if (t >= {1'b0, dvs, 1'b0}) begin
      dsel = {1'b0, dvs, 1'b0};
    end else if (t >= {2'b00, dvs}) begin
      dsel = {2'b00, dvs};
    end else begin
      dsel = 34'd0;
    end
  end
  assign diff = t - dsel;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bsof_pkg::MD_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state)
        bsof_pkg::MD_IDLE: begin
          if (start) begin
            state <= bsof_pkg::MD_MUL;
          end
        end
        bsof_pkg::MD_MUL: begin
          if (step == 5'd0) begin
            state <= bsof_pkg::MD_DIV;
          end
        end
        bsof_pkg::MD_DIV: begin
          if (step == 5'd0) begin
            state  <= bsof_pkg::MD_IDLE;
            done_r <= 1'b1;
          end
        end
        default: state <= bsof_pkg::MD_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bsof_pkg::MD_IDLE: begin
        if (start) begin
          opa  <= op_a;
          dvs  <= op_d;
          w    <= {32'd0, op_b};
          tri3 <= tri_sum;
          step <= MUL_LAST;
        end
      end
      bsof_pkg::MD_MUL: begin
        w <= w_mul;
        if (step == 5'd0) begin
          rem_r <= 32'd0;
          tri3  <= tri_sum;
          step  <= DIV_LAST;
        end else begin
          step <= step - 5'd1;
        end
      end
      bsof_pkg::MD_DIV: begin
        w     <= {w[61:0], 2'b00};
        rem_r <= diff[31:0];
        step  <= step - 5'd1;
      end
      default: begin
        step <= 5'd0;
      end
    endcase
  end

  assign stat.busy = (state != bsof_pkg::MD_IDLE);
  assign stat.done = done_r;
  assign rem       = rem_r;

  `ASSERT_IMPLY(a_rem_below_divisor, clk, rst, done_r, rem_r < dvs, "remainder not below divisor")
  `ASSERT_IMPLY(a_done_after_div, clk, rst, done_r, $past(state) == bsof_pkg::MD_DIV, "done without remainder pass")

endmodule

>>> hdl/bsof_counts.sv
// Bucket hit counters: normal and large banks in one memory with per-entry
// valid bits, registered read. Depends on bsof_pkg.
`timescale 1ns / 1ps

module bsof_counts #(
  parameter int MAX_BLOCKS = bsof_pkg::MAX_BLOCKS_DEF,
  parameter int CNT_W      = 13,
  parameter int IDX_W      = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  bsof_pkg::cnt_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [CNT_W-1:0]    wr_data,
  output logic [CNT_W-1:0]    rd_cnt
);

  localparam int ENTRIES = 2 * MAX_BLOCKS;
  localparam int AW      = $clog2(ENTRIES);

  logic [CNT_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [CNT_W-1:0]   rd_data;
  logic               rd_vld;
  logic [AW-1:0]      addr;

  // Large bank sits above the normal bank
  assign addr = ctrl.upper_bank ? (AW'(MAX_BLOCKS) + AW'(idx)) : AW'(idx);

  // Counter storage
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // Valid bits: clear on line start, upper half on mode switch
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_all) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctrl.clear_large) begin
        vld[ENTRIES-1 -: MAX_BLOCKS] <= '0;
      end
      if (ctrl.wr_en) begin
        vld[addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld <= vld[addr];
      end
    end
  end

  // Entry never written since the last clear reads as zero
  assign rd_cnt = rd_vld ? rd_data : '0;

endmodule

>>> hdl/bucket_sieve_offset_fill_core.sv
// Top level of the bucket sieve offset-fill block: APB registers, sequencer,
// output register. Depends on bsof_pkg, bsof_muldiv, bsof_counts, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// For each prime the block forms start = inverse*(low_residue+class_offset)
// mod prime and, when start lies in the line, takes the slot from the
// bucket's counter. After a prime's transfer the shared unit runs the radix-4
// multiply and then the radix-4 remainder; the sequencer then takes the
// remainder, reads the counter memory and writes it back with the result.
// A zero prime skips the shared unit and the counter and goes straight to
// the final step. A line-start command gives no result. in_ready is high
// only between items, so an item must finish before the next is taken; a
// finished result waits in the output register while the next item is
// already taken, and that item's final step waits until the previous result
// is read. Configuration registers sit at byte addresses 0, 4 and 8. They
// are to be written only while the block is idle; the block itself does not
// enforce this.
module bucket_sieve_offset_fill_core #(
  parameter int MAX_BLOCKS   = bsof_pkg::MAX_BLOCKS_DEF,
  parameter int FLAG_BITS    = bsof_pkg::FLAG_BITS_DEF,
  parameter int SLOT_LIMIT   = bsof_pkg::SLOT_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsof_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bsof_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bsof_pkg::out_item_t            out_data
);

  localparam int CNT_W = $clog2(SLOT_LIMIT + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // Configuration registers
  logic [31:0] class_offset;
  logic [6:0]  blocks_in_use;
  logic [31:0] large_threshold;
  logic        cfg_wr;

  // Sequencer and item state
  bsof_pkg::seq_state_t state, state_next;
  logic               large_active;
  logic [31:0]        prime_r;
  logic [31:0]        start_r;
  logic               hit_r;
  logic [IDX_W-1:0]   idx_r;
  logic [5:0]         bkt_r;
  bsof_pkg::out_item_t out_q;

  logic                accept;
  logic                md_start;
  bsof_pkg::md_stat_t  md_stat;
  logic [31:0]         md_rem;
  bsof_pkg::cnt_ctrl_t cc;
  logic [IDX_W-1:0]    cnt_idx;
  logic [CNT_W-1:0]    rd_cnt;
  logic                fin_go;

  logic [31:0] blk32;
  logic [31:0] blocks_eff;
  logic [31:0] hi32;
  logic        hit_lk;
  logic [31:0] cnt32;
  logic        ovf;
  logic        can_fill;
  logic        switch_mode;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_offset    <= 32'd0;
      blocks_in_use   <= 7'd1;
      large_threshold <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bsof_pkg::REG_CLASS_OFFSET:    class_offset    <= pwdata;
        bsof_pkg::REG_BLOCKS_IN_USE:   blocks_in_use   <= pwdata[6:0];
        bsof_pkg::REG_LARGE_THRESHOLD: large_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bsof_pkg::REG_CLASS_OFFSET:    prdata = class_offset;
      bsof_pkg::REG_BLOCKS_IN_USE:   prdata = {25'd0, blocks_in_use};
      bsof_pkg::REG_LARGE_THRESHOLD: prdata = large_threshold;
      default:                       prdata = 32'd0;
    endcase
  end

  // Shared multiply / remainder unit
  bsof_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .op_a  (in_data.inverse),
    .op_b  (in_data.low_residue + class_offset),
    .op_d  (in_data.prime),
    .stat  (md_stat),
    .rem   (md_rem)
  );

  // Bucket counters
  bsof_counts #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_counts (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cc),
    .idx     (cnt_idx),
    .wr_data (rd_cnt + CNT_W'(1)),
    .rd_cnt  (rd_cnt)
  );

  // Line bound check and bucket pick
  assign blk32      = {25'd0, blocks_in_use};
  assign blocks_eff = (blk32 > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : blk32;
  assign hi32       = start_r >> FLAG_BITS;
  assign hit_lk     = (prime_r != 32'd0) && (hi32 < blocks_eff);
  assign cnt_idx    = (state == bsof_pkg::S_LOOK) ? hi32[IDX_W-1:0] : idx_r;

  // Fill decision
  assign cnt32    = 32'(rd_cnt);
  assign ovf      = hit_r && (cnt32 >= 32'(SLOT_LIMIT));
  assign can_fill = hit_r && !ovf;

  assign accept      = in_valid && in_ready;
  assign switch_mode = !large_active && (in_data.prime > large_threshold);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsof_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    md_start       = 1'b0;
    fin_go         = 1'b0;
    cc.rd_en       = 1'b0;
    cc.wr_en       = 1'b0;
    cc.clear_all   = 1'b0;
    cc.clear_large = 1'b0;
    cc.upper_bank  = large_active;
    case (state)
      bsof_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_data.cmd == bsof_pkg::CMD_LINE) begin
            cc.clear_all = 1'b1;
          end else begin
            cc.clear_large = switch_mode;
            if (in_data.prime != 32'd0) begin
              md_start   = 1'b1;
              state_next = bsof_pkg::S_CALC;
            end else begin
              state_next = bsof_pkg::S_FIN;
            end
          end
        end
      end
      bsof_pkg::S_CALC: begin
        if (md_stat.done) begin
          state_next = bsof_pkg::S_LOOK;
        end
      end
      bsof_pkg::S_LOOK: begin
        cc.rd_en   = 1'b1;
        state_next = bsof_pkg::S_FIN;
      end
      bsof_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          fin_go     = 1'b1;
          cc.wr_en   = can_fill;
          state_next = bsof_pkg::S_IDLE;
        end
      end
      default: state_next = bsof_pkg::S_IDLE;
    endcase
  end

  // Mode flag
  always_ff @(posedge clk) begin
    if (rst) begin
      large_active <= 1'b0;
    end else if (accept) begin
      if (in_data.cmd == bsof_pkg::CMD_LINE) begin
        large_active <= 1'b0;
      end else if (switch_mode) begin
        large_active <= 1'b1;
      end
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (accept && (in_data.cmd == bsof_pkg::CMD_PRIME)) begin
      prime_r <= in_data.prime;
      if (in_data.prime == 32'd0) begin
        start_r <= 32'hFFFF_FFFF;
        hit_r   <= 1'b0;
      end
    end
    if ((state == bsof_pkg::S_CALC) && md_stat.done) begin
      start_r <= md_rem;
    end
    if (state == bsof_pkg::S_LOOK) begin
      hit_r <= hit_lk;
      idx_r <= hi32[IDX_W-1:0];
      bkt_r <= hi32[5:0];
    end
  end

  // Output register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_q.start_offset <= start_r;
      out_q.hit          <= hit_r;
      out_q.bucket       <= hit_r ? bkt_r : 6'd0;
      out_q.slot         <= can_fill ? cnt32[11:0] : 12'd0;
      out_q.entry        <= can_fill ? (large_active ? {32'd0, start_r}
                                                     : {prime_r, start_r})
                                     : 64'd0;
      out_q.large_mode   <= large_active;
      out_q.overflow     <= ovf;
    end
  end

  assign out_data = out_q;

  `ASSERT_IMPLY(a_done_while_waiting, clk, rst, md_stat.done, state == bsof_pkg::S_CALC, "unit finished outside calc wait")
  `ASSERT_IMPLY(a_calc_has_unit, clk, rst, state == bsof_pkg::S_CALC, md_stat.busy || md_stat.done, "calc wait with idle unit")
  `ASSERT_IMPLY(a_miss_no_entry, clk, rst, out_valid && !out_data.hit, !out_data.overflow && (out_data.entry == 64'd0), "entry or overflow without hit")

endmodule
